// ===== design/mexp_pkg.sv =====
// Shared types for the modular exponentiation block.
package mexp_pkg;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_SQR  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_STEP = 6'b010000,
        ST_DONE = 6'b100000
    } mexp_state_t;

    typedef struct packed {
        logic done;
        logic zero_mod;
    } mexp_mul_stat_t;

endpackage

// ===== design/mexp_modmul.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, shift-and-add with reduction.
module mexp_modmul #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [OPERAND_WIDTH-1:0]   p,
    input  logic [OPERAND_WIDTH-1:0]   q,
    input  logic [OPERAND_WIDTH-1:0]   m,
    output logic [OPERAND_WIDTH-1:0]   product,
    output mexp_pkg::mexp_mul_stat_t   stat
);
    import mexp_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  p_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  m_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0] dbl;
    logic [W:0] mext;
    logic [W:0] dred;
    logic [W:0] sum;
    logic [W:0] sred;

    always_comb
    begin
        dbl  = {acc_reg, 1'b0};
        mext = {1'b0, m_reg};
        dred = (dbl >= mext) ? dbl - mext : dbl;
        sum  = dred + {1'b0, p_reg};
        sred = (sum >= mext) ? sum - mext : sum;
        acc_next = q_reg[W-1] ? sred[W-1:0] : dred[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            p_reg   <= p;
            q_reg   <= q;
            m_reg   <= m;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            q_reg   <= {q_reg[W-2:0], 1'b0};
        end
    end

    assign product       = acc_reg;
    assign stat.done     = done_reg;
    assign stat.zero_mod = (m_reg == '0);

endmodule

// ===== design/modular_exponentiation_top.sv =====
// Modular exponentiation by left-to-right square-and-multiply over a shared modular multiplier.
//
// The input stream carries one item per beat: base, exponent and modulus. The block
// returns base to the exponent, reduced by the modulus, as one beat on the output stream.
// An exponent of zero gives 1 for any modulus; a modulus of zero gives 0 for any other case.
// The block works on one item at a time and drops s_axis_tready from the accepted beat
// until its result beat has been taken.
// Sequencing: ST_SCAN first shifts out the leading zero exponent bits, then for each scanned
// exponent bit the block runs a squaring and, for a set bit, a multiplication by the base.
// Each of these products runs through the bit-serial multiplier, with ST_STEP between bits.
// The result is held in an output register with m_axis_tvalid high until m_axis_tready
// is seen; a stalled receiver simply holds the block in that state.
// Reset clears the sequencer and the multiplier control; the block is ready right after.
module modular_exponentiation_top #(
    parameter int OPERAND_WIDTH = 32,
    localparam int IN_W  = ((3 * OPERAND_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((OPERAND_WIDTH + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // base, exponent, modulus
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // result
);
    import mexp_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    mexp_state_t    state_reg, state_next;
    logic [W-1:0]   base_reg, base_next;
    logic [W-1:0]   exp_reg, exp_next;
    logic [W-1:0]   mod_reg, mod_next;
    logic [W-1:0]   y_reg, y_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic           mul_start;
    logic [W-1:0]   mul_p;
    logic [W-1:0]   mul_q;
    logic [W-1:0]   mul_prod;
    logic [W-1:0]   y_mul;
    mexp_mul_stat_t mul_stat;

    mexp_modmul #(
        .OPERAND_WIDTH(W)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .p       (mul_p),
        .q       (mul_q),
        .m       (mod_reg),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        mod_next   = mod_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        mul_start  = 1'b0;
        mul_p      = y_reg;
        mul_q      = y_reg;
        y_mul      = mul_stat.zero_mod ? '0 : mul_prod;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    base_next  = s_axis_tdata[W-1:0];
                    exp_next   = s_axis_tdata[2*W-1:W];
                    mod_next   = s_axis_tdata[3*W-1:2*W];
                    y_next     = W'(1);
                    cnt_next   = CNT_W'(W);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (exp_reg[W-1])
                begin
                    mul_start  = 1'b1;
                    state_next = ST_SQR;
                end
                else
                begin
                    exp_next = {exp_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SQR:
            begin
                if (mul_stat.done)
                begin
                    y_next = y_mul;
                    if (exp_reg[W-1])
                    begin
                        mul_start  = 1'b1;
                        mul_p      = y_mul;
                        mul_q      = base_reg;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        exp_next   = {exp_reg[W-2:0], 1'b0};
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = ST_STEP;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    y_next     = y_mul;
                    exp_next   = {exp_reg[W-2:0], 1'b0};
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_DONE:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        y_reg    <= y_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DONE);
    assign m_axis_tdata  = OUT_W'(y_reg);

endmodule

// ===== design/mexp_chk.sv =====
// Port-level checker for the modular exponentiation block, bound to the top level.
module mexp_chk #(
    parameter int OPERAND_WIDTH = 32,
    localparam int IN_W  = ((3 * OPERAND_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((OPERAND_WIDTH + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic in_beat;
    logic out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> !$isunknown(s_axis_tdata))
        else $error("Input beat offered with unknown data.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output beat changed while stalled.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("Block ready for input while a result is pending.");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready && !m_axis_tvalid)
        else $error("Block not busy after accepting an input beat.");

    a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |=> s_axis_tready && !m_axis_tvalid)
        else $error("Block not ready after its result beat was taken.");

endmodule

bind modular_exponentiation_top mexp_chk #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
) u_mexp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the modular exponentiation block, with directed and random beats.
`timescale 1ns / 1ps

module tb_top;

    localparam int OPW            = 32;
    localparam int RANDOM_ITEMS   = 270;
    localparam int TAIL_ITEMS     = 30;
    localparam int HOLD_AT_ITEM   = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic           known;
        logic [OPW-1:0] base;
        logic [OPW-1:0] exponent;
        logic [OPW-1:0] modulus;
        logic [OPW-1:0] result;
    } pow_row_t;

    typedef struct packed {
        logic [OPW-1:0] base;
        logic [OPW-1:0] exponent;
        logic [OPW-1:0] modulus;
        logic [OPW-1:0] result;
    } pow_expect_t;

    localparam int DIRECTED_ITEMS = 20;
    localparam pow_row_t DIRECTED_TABLE [DIRECTED_ITEMS] = '{
        '{1'b1, 32'd0,          32'd0,          32'd0,          32'd1},
        '{1'b1, 32'hFFFFFFFF,   32'd0,          32'd1,          32'd1},
        '{1'b1, 32'hFFFFFFFF,   32'd0,          32'hFFFFFFFF,   32'd1},
        '{1'b1, 32'd5,          32'd5,          32'd0,          32'd0},
        '{1'b1, 32'hFFFFFFFF,   32'hFFFFFFFF,   32'd0,          32'd0},
        '{1'b1, 32'd12345,      32'd7,          32'd1,          32'd0},
        '{1'b1, 32'd0,          32'd3,          32'd7,          32'd0},
        '{1'b1, 32'd2,          32'd10,         32'd1000,       32'd24},
        '{1'b1, 32'hFFFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFF,   32'd0},
        '{1'b1, 32'hFFFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFE,   32'd1},
        '{1'b1, 32'd10,         32'd1,          32'd3,          32'd1},
        '{1'b1, 32'd3,          32'd1,          32'hFFFFFFFF,   32'd3},
        '{1'b1, 32'hFFFFFFFE,   32'd2,          32'hFFFFFFFF,   32'd1},
        '{1'b1, 32'd1,          32'hFFFFFFFF,   32'd12345,      32'd1},
        '{1'b1, 32'd7,          32'd1,          32'h80000000,   32'd7},
        '{1'b0, 32'hFFFFFFFF,   32'hFFFFFFFF,   32'hFFFFFFFB,   32'd0},
        '{1'b0, 32'h80000000,   32'h80000000,   32'hFFFFFFFF,   32'd0},
        '{1'b0, 32'hDEADBEEF,   32'hAAAAAAAA,   32'h55555555,   32'd0},
        '{1'b0, 32'h12345678,   32'h00010001,   32'hFFFFFFF1,   32'd0},
        '{1'b0, 32'd3,          32'hFFFFFFFE,   32'h7FFFFFFF,   32'd0}
    };

    logic            clk = 1'b0;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [95:0]     s_axis_tdata;   // base, exponent, modulus
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [31:0]     m_axis_tdata;   // result

    pow_expect_t     pending_pow [$];
    int              error_count = 0;
    int              items_sent = 0;
    bit              tail_phase = 1'b0;
    int              quiet_cycles = 0;

    modular_exponentiation_top #(
        .OPERAND_WIDTH(OPW)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [OPW-1:0] mul_mod(input logic [OPW-1:0] p, q, m);
        logic [2*OPW-1:0] prod;
        if (m == '0)
        begin
            return '0;
        end
        prod = (2*OPW)'(p % m) * (2*OPW)'(q % m);
        return OPW'(prod % (2*OPW)'(m));
    endfunction

    function automatic logic [OPW-1:0] mod_pow(input logic [OPW-1:0] b, e, m);
        logic [OPW-1:0] y;
        bit             started;
        y = 1;
        started = 1'b0;
        for (int i = OPW - 1; i >= 0; i--)
        begin
            if (e[i])
            begin
                started = 1'b1;
            end
            if (started)
            begin
                y = mul_mod(y, y, m);
                if (e[i])
                begin
                    y = mul_mod(y, b, m);
                end
            end
        end
        return y;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic offer_item(input logic [OPW-1:0] b, e, m, input logic known,
                              input logic [OPW-1:0] fixed);
        pow_expect_t exp_item;
        if (!tail_phase && ((items_sent / 16) % 3 != 0) && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {m, e, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        exp_item.base     = b;
        exp_item.exponent = e;
        exp_item.modulus  = m;
        exp_item.result   = known ? fixed : mod_pow(b, e, m);
        pending_pow.push_back(exp_item);
        items_sent++;
    endtask

    initial
    begin
        logic [OPW-1:0] b;
        logic [OPW-1:0] e;
        logic [OPW-1:0] m;
        int             k;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ITEMS; i++)
        begin
            offer_item(DIRECTED_TABLE[i].base, DIRECTED_TABLE[i].exponent,
                       DIRECTED_TABLE[i].modulus, DIRECTED_TABLE[i].known,
                       DIRECTED_TABLE[i].result);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - TAIL_ITEMS)
            begin
                tail_phase = 1'b1;
            end
            case ($urandom_range(0, 9))
                0:       m = '0;
                1:       m = 1;
                2:       m = '1;
                3:       m = 32'h1 << $urandom_range(1, 31);
                4, 5:    m = $urandom_range(2, 1000);
                default: m = $urandom();
            endcase
            case ($urandom_range(0, 7))
                0:       b = '0;
                1:       b = 1;
                2:       b = m;
                3:       b = '1;
                4:       b = $urandom_range(0, 255);
                default: b = $urandom();
            endcase
            case ($urandom_range(0, 15))
                0:       e = '0;
                1:       e = '1;
                2:       e = 32'h80000000 | $urandom();
                default:
                begin
                    k = $urandom_range(0, OPW - 1);
                    e = $urandom() >> (OPW - 1 - k);
                    e[k] = 1'b1;
                end
            endcase
            offer_item(b, e, m, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_pow.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        int  rx_cycles;
        bit  hold_done;
        rx_cycles = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (!hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!tail_phase && ((rx_cycles / 500) % 3 != 0) && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pow_expect_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pow.size() == 0)
            begin
                report_mismatch($sformatf("result beat %h with no item pending", m_axis_tdata));
            end
            else
            begin
                want = pending_pow.pop_front();
                if (m_axis_tdata !== want.result)
                begin
                    report_mismatch($sformatf("%h ^ %h mod %h: result %h, expected %h",
                                              want.base, want.exponent, want.modulus,
                                              m_axis_tdata, want.result));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no beat moved for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
